[rtl/ethernet_bridge_ingress_classifier_assert.svh]
// Assertion macros used by the ingress classifier sequencer (ebic_ctrl).
`ifndef ETHERNET_BRIDGE_INGRESS_CLASSIFIER_ASSERT_SVH
`define ETHERNET_BRIDGE_INGRESS_CLASSIFIER_ASSERT_SVH

// Clocked check on clk_i, held off while rst_ni is low.
`define EBIC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Clocked check that a condition never holds.
`define EBIC_ASSERT_NEVER(name, cond, msg) \
  `EBIC_ASSERT(name, !(cond), msg)

`endif

[rtl/ebic_pkg.sv]
// Types and constants of the ethernet bridge ingress classifier.
`default_nettype none

package ebic_pkg;

  localparam int unsigned MacW     = 48;
  localparam int unsigned EtypeW   = 16;
  localparam int unsigned PortW    = 3;
  localparam int unsigned MaskW    = 8;
  localparam int unsigned EntIdxW  = 4;
  localparam int unsigned IdxExtW  = 6;
  localparam int unsigned ApbDataW = 64;
  localparam int unsigned ApbAddrW = 5;

  localparam logic [MacW-1:0]   LinkLocalBase = 48'h0180_C200_0000;
  localparam logic [MacW-1:0]   LinkLocalMask = 48'hFFFF_FFFF_FFF0;
  localparam logic [EtypeW-1:0] EtherTypePtp  = 16'h88F7;
  localparam int unsigned       GroupBitPos   = 40;

  localparam logic [1:0] RegBridgeMac = 2'd0;
  localparam logic [1:0] RegPortUp    = 2'd1;
  localparam logic [1:0] RegMember    = 2'd2;

  typedef enum logic [2:0] {
    ActDrop     = 3'd0,
    ActContinue = 3'd1,
    ActFlood    = 3'd2,
    ActLocal    = 3'd3,
    ActForward  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    SelForward = 2'd0,
    SelTail0   = 2'd1,
    SelTail1   = 2'd2
  } out_sel_e;

  typedef struct packed {
    logic     capture;
    logic     write;
    logic     rd_en;
    logic     note_hit;
    logic     out_load;
    out_sel_e out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic fwd;
    logic out_free;
    logic tail_two;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/ebic_ctrl.sv]
// Sequencer of the ingress classifier: accepts words, scans the table, issues results.
`default_nettype none

`include "ethernet_bridge_ingress_classifier_assert.svh"

module ebic_ctrl #(
  parameter int unsigned FDB_DEPTH = 16,
  localparam int unsigned IdxW = (FDB_DEPTH > 1) ? $clog2(FDB_DEPTH) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  op_i,
  output      logic                  in_ready_o,
  input  wire ebic_pkg::dp_status_t  status_i,
  output      ebic_pkg::dp_cmd_t     cmd_o,
  output      logic [IdxW-1:0]       rd_addr_o
);
  import ebic_pkg::*;

  localparam int unsigned CntW = $clog2(FDB_DEPTH + 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StTail0,
    StTail1
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] ptr_q;
  logic            pend_q;
  logic            emit;
  logic            advance;
  logic            in_range;

  assign in_range   = ptr_q < CntW'(FDB_DEPTH);
  assign emit       = pend_q && status_i.fwd;
  assign advance    = !emit || status_i.out_free;
  assign in_ready_o = (state_q == StIdle);
  assign rd_addr_o  = ptr_q[IdxW-1:0];

  always_comb begin
    cmd_o = '0;
    cmd_o.out_sel = SelForward;
    unique case (state_q)
      StIdle: begin
        cmd_o.capture = in_valid_i;
        cmd_o.write   = in_valid_i && op_i;
      end
      StScan: begin
        cmd_o.rd_en    = advance && in_range;
        cmd_o.note_hit = pend_q && status_i.hit && advance;
        cmd_o.out_load = emit && status_i.out_free;
        cmd_o.out_sel  = SelForward;
      end
      StTail0: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_sel  = SelTail0;
      end
      StTail1: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_sel  = SelTail1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && !op_i) begin
            state_q <= StScan;
            ptr_q   <= '0;
            pend_q  <= 1'b0;
          end
        end
        StScan: begin
          if (advance) begin
            pend_q <= in_range;
            if (in_range) begin
              ptr_q <= ptr_q + CntW'(1);
            end else begin
              state_q <= StTail0;
            end
          end
        end
        StTail0: begin
          if (status_i.out_free) begin
            state_q <= status_i.tail_two ? StTail1 : StIdle;
          end
        end
        StTail1: begin
          if (status_i.out_free) begin
            state_q <= StIdle;
          end
        end
      endcase
    end
  end

  `EBIC_ASSERT(a_ptr_bound, ptr_q <= CntW'(FDB_DEPTH), "scan pointer beyond table")
  `EBIC_ASSERT(a_pend_scan, pend_q |-> state_q == StScan, "pending read outside scan")
  `EBIC_ASSERT(a_load_free, cmd_o.out_load |-> status_i.out_free, "result overwritten")
  `EBIC_ASSERT_NEVER(a_rd_range, cmd_o.rd_en && !in_range, "table read out of range")

endmodule

`default_nettype wire

[rtl/ebic_datapath.sv]
// Datapath of the ingress classifier: forwarding table, match logic and result register.
`default_nettype none

module ebic_datapath #(
  parameter int unsigned FDB_DEPTH = 16,
  localparam int unsigned IdxW = (FDB_DEPTH > 1) ? $clog2(FDB_DEPTH) : 1
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire ebic_pkg::dp_cmd_t              cmd_i,
  input  wire logic [IdxW-1:0]                rd_addr_i,
  output      ebic_pkg::dp_status_t           status_o,
  input  wire logic [ebic_pkg::MacW-1:0]      dst_mac_i,
  input  wire logic [ebic_pkg::EtypeW-1:0]    ether_type_i,
  input  wire logic [ebic_pkg::PortW-1:0]     ingress_port_i,
  input  wire logic [ebic_pkg::EntIdxW-1:0]   entry_index_i,
  input  wire logic                           entry_valid_i,
  input  wire logic [ebic_pkg::MacW-1:0]      entry_mac_i,
  input  wire logic [ebic_pkg::PortW-1:0]     entry_port_i,
  input  wire logic [ebic_pkg::MacW-1:0]      bridge_mac_i,
  input  wire logic [ebic_pkg::MaskW-1:0]     port_up_mask_i,
  input  wire logic [ebic_pkg::MaskW-1:0]     member_mask_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic [2:0]                     action_o,
  output      logic [ebic_pkg::PortW-1:0]     egress_port_o,
  output      logic [ebic_pkg::PortW-1:0]     source_port_o,
  output      logic                           last_o
);
  import ebic_pkg::*;

  logic [MacW-1:0]      mac_mem [FDB_DEPTH];
  logic [PortW-1:0]     port_mem [FDB_DEPTH];
  logic [FDB_DEPTH-1:0] valid_q;

  logic [MacW-1:0]   dst_q;
  logic [EtypeW-1:0] etype_q;
  logic [PortW-1:0]  src_q;
  logic              matched_q;

  logic [MacW-1:0]  rd_mac_q;
  logic [PortW-1:0] rd_port_q;
  logic             rd_valid_q;

  logic             out_valid_q;
  action_e          out_action_q;
  logic [PortW-1:0] out_egress_q;
  logic [PortW-1:0] out_source_q;
  logic             out_last_q;

  logic [IdxExtW-1:0] wr_ext;
  logic [IdxW-1:0]    wr_addr;
  logic               wr_en;
  logic               hit;
  logic               out_free;
  action_e            act0;
  action_e            act1;
  logic               two;

  assign wr_ext  = IdxExtW'(entry_index_i);
  assign wr_addr = wr_ext[IdxW-1:0];
  assign wr_en   = cmd_i.write && (wr_ext < IdxExtW'(FDB_DEPTH));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mac_mem[wr_addr]  <= entry_mac_i;
      port_mem[wr_addr] <= entry_port_i;
    end
    if (cmd_i.rd_en) begin
      rd_mac_q   <= mac_mem[rd_addr_i];
      rd_port_q  <= port_mem[rd_addr_i];
      rd_valid_q <= valid_q[rd_addr_i];
    end
    if (cmd_i.capture) begin
      dst_q   <= dst_mac_i;
      etype_q <= ether_type_i;
      src_q   <= ingress_port_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      matched_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[wr_addr] <= entry_valid_i;
      end
      if (cmd_i.capture) begin
        matched_q <= 1'b0;
      end else if (cmd_i.note_hit) begin
        matched_q <= 1'b1;
      end
    end
  end

  assign hit = rd_valid_q && (rd_mac_q == dst_q) && member_mask_i[rd_port_q];

  always_comb begin
    priority if ((dst_q & LinkLocalMask) == LinkLocalBase) begin
      act0 = ActDrop;
      act1 = ActDrop;
      two  = 1'b0;
    end else if (etype_q == EtherTypePtp) begin
      act0 = ActContinue;
      act1 = ActDrop;
      two  = 1'b0;
    end else if (dst_q[GroupBitPos]) begin
      act0 = ActFlood;
      act1 = ActLocal;
      two  = 1'b1;
    end else if (dst_q == bridge_mac_i) begin
      act0 = ActLocal;
      act1 = ActDrop;
      two  = 1'b0;
    end else begin
      act0 = ActFlood;
      act1 = ActDrop;
      two  = 1'b1;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.hit      = hit;
  assign status_o.fwd      = hit && port_up_mask_i[rd_port_q];
  assign status_o.out_free = out_free;
  assign status_o.tail_two = !matched_q && two;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_source_q <= src_q;
      unique case (cmd_i.out_sel)
        SelForward: begin
          out_action_q <= ActForward;
          out_egress_q <= rd_port_q;
          out_last_q   <= 1'b0;
        end
        SelTail0: begin
          out_action_q <= matched_q ? ActDrop : act0;
          out_egress_q <= '0;
          out_last_q   <= matched_q || !two;
        end
        default: begin
          out_action_q <= act1;
          out_egress_q <= '0;
          out_last_q   <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = out_action_q;
  assign egress_port_o = out_egress_q;
  assign source_port_o = out_source_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire

[rtl/ethernet_bridge_ingress_classifier.sv]
// A classify word holds off the next word until its scan and its closing results have been
// issued, plus any output stall; a write is taken in the idle state without leaving it.
// A forwarding hit yields a result during the scan; the closing results always follow the scan.
// The scan reads one entry per cycle via the registered read port, holding while a result stalls.
// Results leave through one output register, so the next word is taken while the last waits.
// Reset clears the table valid bits, the sequencer, the config registers and the output valid flag.
`default_nettype none

module ethernet_bridge_ingress_classifier #(
  parameter int unsigned FDB_DEPTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ebic_pkg::ApbAddrW-1:0]     paddr,
  input  wire logic [ebic_pkg::ApbDataW-1:0]     pwdata,
  output      logic [ebic_pkg::ApbDataW-1:0]     prdata,
  output      logic                              pready,
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic                              op_i,
  input  wire logic [ebic_pkg::MacW-1:0]         dst_mac_i,
  input  wire logic [ebic_pkg::EtypeW-1:0]       ether_type_i,
  input  wire logic [ebic_pkg::PortW-1:0]        ingress_port_i,
  input  wire logic [ebic_pkg::EntIdxW-1:0]      entry_index_i,
  input  wire logic                              entry_valid_i,
  input  wire logic [ebic_pkg::MacW-1:0]         entry_mac_i,
  input  wire logic [ebic_pkg::PortW-1:0]        entry_port_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic [2:0]                        action_o,
  output      logic [ebic_pkg::PortW-1:0]        egress_port_o,
  output      logic [ebic_pkg::PortW-1:0]        source_port_o,
  output      logic                              last_o
);
  import ebic_pkg::*;

  localparam int unsigned IdxW = (FDB_DEPTH > 1) ? $clog2(FDB_DEPTH) : 1;

  logic [MacW-1:0]  bridge_mac_q;
  logic [MaskW-1:0] port_up_q;
  logic [MaskW-1:0] member_q;
  logic [1:0]       reg_idx;
  logic             cfg_wr;
  logic             in_ready;
  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [IdxW-1:0]  rd_addr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bridge_mac_q <= '0;
      port_up_q    <= '0;
      member_q     <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegBridgeMac: bridge_mac_q <= pwdata[MacW-1:0];
        RegPortUp:    port_up_q    <= pwdata[MaskW-1:0];
        RegMember:    member_q     <= pwdata[MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegBridgeMac: prdata = ApbDataW'(bridge_mac_q);
      RegPortUp:    prdata = ApbDataW'(port_up_q);
      RegMember:    prdata = ApbDataW'(member_q);
      default:      prdata = '0;
    endcase
  end

  assign in_stall_o = !in_ready;

  ebic_ctrl #(
    .FDB_DEPTH (FDB_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  ebic_datapath #(
    .FDB_DEPTH (FDB_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rd_addr_i      (rd_addr),
    .status_o       (status),
    .dst_mac_i      (dst_mac_i),
    .ether_type_i   (ether_type_i),
    .ingress_port_i (ingress_port_i),
    .entry_index_i  (entry_index_i),
    .entry_valid_i  (entry_valid_i),
    .entry_mac_i    (entry_mac_i),
    .entry_port_i   (entry_port_i),
    .bridge_mac_i   (bridge_mac_q),
    .port_up_mask_i (port_up_q),
    .member_mask_i  (member_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_o       (action_o),
    .egress_port_o  (egress_port_o),
    .source_port_o  (source_port_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire
